FILE: rtl/core/bd128_pkg.sv
// Package with the sizes, types and handoff struct of the binary to decimal converter.
`default_nettype none
package bd128_pkg;

  // Width of the converted value; bits above it are ignored.
  localparam int VALUE_BITS = 128;
  localparam int HALF_BITS  = 64;

  // Decimal digits needed for the largest value: floor(bits * log10(2)) + 1.
  localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_W  = DIGITS * 4;
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int REM_W  = $clog2(DIGITS + 1);

  typedef logic [VALUE_BITS-1:0] bin_t;
  typedef logic [BCD_W-1:0]      bcd_t;
  typedef logic [3:0]            digit_t;

  // Finished conversion passed from the converter to the digit emitter.
  typedef struct packed {
    logic valid;
    bcd_t bcd;
  } hand_t;

endpackage
`default_nettype wire

FILE: rtl/core/bd128_if.sv
// Handshake channels for the input value word and the output digit word.
`default_nettype none
interface bd128_in_if;
  logic                           valid;
  logic                           ready;
  logic [bd128_pkg::HALF_BITS-1:0] value_high;
  logic [bd128_pkg::HALF_BITS-1:0] value_low;

  modport source (output valid, output value_high, output value_low, input ready);
  modport sink   (input valid, input value_high, input value_low, output ready);
endinterface

interface bd128_out_if;
  logic                  valid;
  logic                  ready;
  logic [3:0]            digit;
  logic                  last_digit;

  modport source (output valid, output digit, output last_digit, input ready);
  modport sink   (input valid, input digit, input last_digit, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/bd128_conv.sv
// Shift-and-add-3 converter: one shared digit correction pass per input bit.
`default_nettype none
module bd128_conv (
  input  wire logic             clk,
  input  wire logic             rst,
  bd128_in_if.sink              value_ch,
  output bd128_pkg::hand_t      hand,
  input  wire logic             hand_ready
);
  import bd128_pkg::*;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_RUN  = 2'd1;
  localparam logic [1:0] C_HOLD = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] cnt;
  bin_t             bin;
  bcd_t             bcd;
  bcd_t             adj;
  logic [2*HALF_BITS-1:0] full;

  assign full = {value_ch.value_high, value_ch.value_low};
  assign value_ch.ready = (state == C_IDLE);
  assign hand = {(state == C_HOLD), bcd};

  // Every digit of five or more gets three added before the shift doubles it.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        C_IDLE: begin
          if (value_ch.valid) begin
            state <= C_RUN;
            cnt   <= CNT_W'(VALUE_BITS);
          end
        end
        C_RUN: begin
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= C_HOLD;
          end
        end
        C_HOLD: begin
          if (hand_ready) begin
            state <= C_IDLE;
          end
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == C_IDLE && value_ch.valid) begin
      bin <= full[VALUE_BITS-1:0];
      bcd <= '0;
    end else if (state == C_RUN) begin
      bcd <= {adj[BCD_W-2:0], bin[VALUE_BITS-1]};
      bin <= {bin[VALUE_BITS-2:0], 1'b0};
    end
  end

`ifndef ASSERT_OFF
  a_run_cnt: assert property (@(posedge clk) disable iff (rst)
    state == C_RUN |-> cnt != '0)
    else $error("conversion pass running with no bits left");
  a_hold_after_run: assert property (@(posedge clk) disable iff (rst)
    $rose(hand.valid) |-> $past(state) == C_RUN && $past(cnt) == CNT_W'(1))
    else $error("result offered before all bits were shifted in");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state == C_RUN || state == C_HOLD) |-> !value_ch.ready)
    else $error("new value taken while a conversion is in flight");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/bd128_emit.sv
// Digit emitter: drops leading zeros, then sends the digits most significant first.
`default_nettype none
module bd128_emit (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire bd128_pkg::hand_t hand,
  output logic                  hand_ready,
  bd128_out_if.source           digit_ch
);
  import bd128_pkg::*;

  localparam logic [1:0] E_IDLE = 2'd0;
  localparam logic [1:0] E_SCAN = 2'd1;
  localparam logic [1:0] E_EMIT = 2'd2;

  logic [1:0]       state;
  logic [REM_W-1:0] rem;
  bcd_t             digs;
  digit_t           top;
  logic             shift;

  assign top        = digs[BCD_W-1 -: 4];
  assign hand_ready = (state == E_IDLE);

  assign digit_ch.valid      = (state == E_EMIT);
  assign digit_ch.digit      = top;
  assign digit_ch.last_digit = (rem == REM_W'(1));

  // The digit register moves up one digit on a skipped zero or a taken word.
  assign shift = (state == E_SCAN && top == 4'd0 && rem != REM_W'(1)) ||
                 (state == E_EMIT && digit_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      rem   <= '0;
    end else begin
      case (state)
        E_IDLE: begin
          if (hand.valid) begin
            state <= E_SCAN;
            rem   <= REM_W'(DIGITS);
          end
        end
        E_SCAN: begin
          if (shift) begin
            rem <= rem - REM_W'(1);
          end else begin
            state <= E_EMIT;
          end
        end
        E_EMIT: begin
          if (digit_ch.ready) begin
            rem <= rem - REM_W'(1);
            if (rem == REM_W'(1)) begin
              state <= E_IDLE;
            end
          end
        end
        default: begin
          state <= E_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == E_IDLE && hand.valid) begin
      digs <= hand.bcd;
    end else if (shift) begin
      digs <= {digs[BCD_W-5:0], 4'd0};
    end
  end

`ifndef ASSERT_OFF
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    digit_ch.valid |-> digit_ch.digit <= 4'd9)
    else $error("digit word outside 0 to 9");
  a_rem_live: assert property (@(posedge clk) disable iff (rst)
    state != E_IDLE |-> rem != '0)
    else $error("emitter busy with no digits left");
  a_lead_nonzero: assert property (@(posedge clk) disable iff (rst)
    $rose(digit_ch.valid) |-> digit_ch.digit != 4'd0 || digit_ch.last_digit)
    else $error("leading zero sent");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/unsigned_binary_to_decimal_128_unit.sv
// Top level of the 128-bit unsigned binary to decimal converter.
// A value word arrives as two 64-bit halves and leaves as a run of decimal digit
// words, most significant first, with leading zeros dropped; the final digit word
// carries last_digit, and a zero value gives the single digit 0. The converter
// runs a shift-and-add-3 pass with one shared correction unit over all 39 BCD
// digits, one pass per input bit, and holds ready low through the pass and until
// the emitter takes the result. The emitter then skips each leading zero in turn
// (up to 38), turns to output, and sends one digit per cycle while the sink is
// ready; leading zeros and digits always add up to 39. Both stages work at once,
// so a steady stream is paced by the conversion pass; only sink stalls that
// stretch emission past it slow it down.
`default_nettype none
module unsigned_binary_to_decimal_128_unit (
  input  wire logic    clk,
  input  wire logic    rst,
  bd128_in_if.sink     value_ch,
  bd128_out_if.source  digit_ch
);
  import bd128_pkg::*;

  hand_t hand;
  logic  hand_ready;

  // Converter: binary value in, finished BCD word out.
  bd128_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .value_ch   (value_ch),
    .hand       (hand),
    .hand_ready (hand_ready)
  );

  // Emitter: BCD word in, one digit word per handshake out.
  bd128_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .hand       (hand),
    .hand_ready (hand_ready),
    .digit_ch   (digit_ch)
  );

endmodule
`default_nettype wire
